[rtl/assert_macros.svh]
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/twppf_pkg.sv]
// Shared types and constants of the two-window pulse peak finder.
`timescale 1ns / 1ps

package twppf_pkg;

  localparam int unsigned IdxFullW = 16;
  localparam int unsigned ValW     = 16;
  localparam int unsigned OutIdxW  = 11;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 1;

  localparam logic [OutIdxW-1:0] DeltaTop = 11'd2047;
  localparam logic [OutIdxW-1:0] SplitRst = 11'd1023;

  localparam logic [CfgIdxW-1:0] RegTriggerLevel = 1'b0;
  localparam logic [CfgIdxW-1:0] RegSplitIndex   = 1'b1;

  typedef struct packed {
    logic [IdxFullW-1:0]     idx;
    logic signed [ValW-1:0]  level;
  } peak_t;

  typedef struct packed {
    peak_t one;
    peak_t two;
  } wave_end_t;

endpackage

[rtl/twppf_track.sv]
// Sample counter, configuration registers and per-window peak tracking.
`timescale 1ns / 1ps

module twppf_track #(
  parameter int unsigned WAVE_LEN    = 2048,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [twppf_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [twppf_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic                                step_i,
  input  logic signed [SAMPLE_BITS-1:0]       sample_i,
  input  logic                                last_i,
  output twppf_pkg::wave_end_t                peaks_o
);

  localparam int unsigned CntW  = $clog2(WAVE_LEN + 1);
  localparam int unsigned IdxW  = $clog2(WAVE_LEN);
  localparam int unsigned CmpW  = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;
  localparam int unsigned CmpIW = (CntW > twppf_pkg::OutIdxW) ? CntW : twppf_pkg::OutIdxW;

  logic signed [15:0]                 trig_q;
  logic [twppf_pkg::OutIdxW-1:0]      split_q;
  logic [CntW-1:0]                    count_q, count_d, count_upd;
  logic [IdxW-1:0]                    p1_idx_q, p1_idx_d, p1_idx_upd;
  logic [IdxW-1:0]                    p2_idx_q, p2_idx_d, p2_idx_upd;
  logic signed [SAMPLE_BITS-1:0]      p1_lvl_q, p1_lvl_d, p1_lvl_upd;
  logic signed [SAMPLE_BITS-1:0]      p2_lvl_q, p2_lvl_d, p2_lvl_upd;
  logic                               in_range, hit, first_win;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_q  <= '0;
      split_q <= twppf_pkg::SplitRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        twppf_pkg::RegTriggerLevel: trig_q  <= $signed(cfg_data_i);
        twppf_pkg::RegSplitIndex:   split_q <= cfg_data_i[twppf_pkg::OutIdxW-1:0];
        default: ;
      endcase
    end
  end

  assign in_range  = count_q < CntW'(WAVE_LEN);
  assign hit       = CmpW'(sample_i) <= CmpW'(trig_q);
  assign first_win = CmpIW'(count_q) <= CmpIW'(split_q);

  always_comb begin
    count_upd  = count_q;
    p1_idx_upd = p1_idx_q;
    p1_lvl_upd = p1_lvl_q;
    p2_idx_upd = p2_idx_q;
    p2_lvl_upd = p2_lvl_q;
    if (in_range) begin
      count_upd = count_q + 1'b1;
      if (hit) begin
        if (first_win) begin
          if (sample_i < p1_lvl_q) begin
            p1_idx_upd = count_q[IdxW-1:0];
            p1_lvl_upd = sample_i;
          end
        end else if (sample_i < p2_lvl_q) begin
          p2_idx_upd = count_q[IdxW-1:0];
          p2_lvl_upd = sample_i;
        end
      end
    end

    count_d  = count_q;
    p1_idx_d = p1_idx_q;
    p1_lvl_d = p1_lvl_q;
    p2_idx_d = p2_idx_q;
    p2_lvl_d = p2_lvl_q;
    if (step_i) begin
      if (last_i) begin
        count_d  = '0;
        p1_idx_d = '0;
        p1_lvl_d = '0;
        p2_idx_d = '0;
        p2_lvl_d = '0;
      end else begin
        count_d  = count_upd;
        p1_idx_d = p1_idx_upd;
        p1_lvl_d = p1_lvl_upd;
        p2_idx_d = p2_idx_upd;
        p2_lvl_d = p2_lvl_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      p1_idx_q <= '0;
      p1_lvl_q <= '0;
      p2_idx_q <= '0;
      p2_lvl_q <= '0;
    end else begin
      count_q  <= count_d;
      p1_idx_q <= p1_idx_d;
      p1_lvl_q <= p1_lvl_d;
      p2_idx_q <= p2_idx_d;
      p2_lvl_q <= p2_lvl_d;
    end
  end

  assign peaks_o.one.idx   = twppf_pkg::IdxFullW'(p1_idx_upd);
  assign peaks_o.one.level = twppf_pkg::ValW'(p1_lvl_upd);
  assign peaks_o.two.idx   = twppf_pkg::IdxFullW'(p2_idx_upd);
  assign peaks_o.two.level = twppf_pkg::ValW'(p2_lvl_upd);

endmodule

[rtl/twppf_result.sv]
// Pair check, delta statistics and the result register.
`timescale 1ns / 1ps

module twppf_result (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                load_i,
  input  twppf_pkg::wave_end_t                peaks_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [twppf_pkg::OutIdxW-1:0]       first_index_o,
  output logic signed [twppf_pkg::ValW-1:0]   first_value_o,
  output logic [twppf_pkg::OutIdxW-1:0]       second_index_o,
  output logic signed [twppf_pkg::ValW-1:0]   second_value_o,
  output logic                                pair_valid_o,
  output logic [twppf_pkg::OutIdxW-1:0]       delta_samples_o,
  output logic [twppf_pkg::OutIdxW-1:0]       delta_min_o,
  output logic [twppf_pkg::OutIdxW-1:0]       delta_max_o
);

  logic                                pair_ok;
  logic [twppf_pkg::IdxFullW-1:0]      diff;
  logic [twppf_pkg::OutIdxW-1:0]       delta;
  logic [twppf_pkg::OutIdxW-1:0]       min_q, min_d, max_q, max_d;
  logic                                valid_q, valid_d;

  assign pair_ok = (peaks_i.one.idx != '0) && (peaks_i.two.idx != '0);
  assign diff    = (peaks_i.two.idx >= peaks_i.one.idx) ?
                   (peaks_i.two.idx - peaks_i.one.idx) : '0;

  always_comb begin
    delta = '0;
    if (pair_ok) begin
      delta = (diff > twppf_pkg::IdxFullW'(twppf_pkg::DeltaTop)) ?
              twppf_pkg::DeltaTop : diff[twppf_pkg::OutIdxW-1:0];
    end
    min_d = min_q;
    max_d = max_q;
    if (load_i && pair_ok) begin
      if (delta < min_q) min_d = delta;
      if (delta > max_q) max_d = delta;
    end
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q   <= twppf_pkg::DeltaTop;
      max_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      min_q   <= min_d;
      max_q   <= max_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      first_index_o   <= peaks_i.one.idx[twppf_pkg::OutIdxW-1:0];
      first_value_o   <= peaks_i.one.level;
      second_index_o  <= peaks_i.two.idx[twppf_pkg::OutIdxW-1:0];
      second_value_o  <= peaks_i.two.level;
      pair_valid_o    <= pair_ok;
      delta_samples_o <= delta;
      delta_min_o     <= min_d;
      delta_max_o     <= max_d;
    end
  end

  assign out_valid_o = valid_q;

endmodule

[rtl/two_window_pulse_peak_finder.sv]
// Top level of the two-window pulse peak finder.
//
// Usage: samples enter on the in_valid_i/in_ready_o channel, one transfer per
// sample, with last_sample_i high on the final sample of a waveform. Samples
// are numbered from 0; those at or before split_index form the first window.
// Each window keeps its most negative sample at or below trigger_level and
// below zero. The last sample produces one result transfer on
// out_valid_o/out_ready_i carrying both peaks, pair status, the delta and the
// running delta min/max. Other samples produce no result.
// Throughput: one sample per cycle, set by the single compare-and-update pass,
// except while a last sample is held back by a pending result. Path: the last
// sample enters the input register at its transfer, then loads the result register.
// Stall: while a result waits, non-last samples keep flowing; a following
// last sample waits in the input register and in_ready_o drops until the
// pending result is taken.
// Reset: clears peaks and count, trigger_level to 0, split_index to 1023,
// delta min to 2047 and delta max to 0. Configure only while idle.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module two_window_pulse_peak_finder #(
  parameter int unsigned WAVE_LEN    = 2048,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [twppf_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [twppf_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]       sample_i,
  input  logic                                last_sample_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [twppf_pkg::OutIdxW-1:0]       first_index_o,
  output logic signed [twppf_pkg::ValW-1:0]   first_value_o,
  output logic [twppf_pkg::OutIdxW-1:0]       second_index_o,
  output logic signed [twppf_pkg::ValW-1:0]   second_value_o,
  output logic                                pair_valid_o,
  output logic [twppf_pkg::OutIdxW-1:0]       delta_samples_o,
  output logic [twppf_pkg::OutIdxW-1:0]       delta_min_o,
  output logic [twppf_pkg::OutIdxW-1:0]       delta_max_o
);

  logic                           s1_valid_q, s1_valid_d;
  logic signed [SAMPLE_BITS-1:0]  s1_sample_q;
  logic                           s1_last_q;
  logic                           s1_go, in_xfer;
  twppf_pkg::wave_end_t           peaks;

  assign s1_go      = s1_valid_q && (!s1_last_q || !out_valid_o || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_go;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_xfer) begin
      s1_valid_d = 1'b1;
    end else if (s1_go) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_sample_q <= sample_i;
      s1_last_q   <= last_sample_i;
    end
  end

  twppf_track #(
    .WAVE_LEN   (WAVE_LEN),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_track (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .step_i    (s1_go),
    .sample_i  (s1_sample_q),
    .last_i    (s1_last_q),
    .peaks_o   (peaks)
  );

  twppf_result u_result (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (s1_go && s1_last_q),
    .peaks_i        (peaks),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .first_index_o  (first_index_o),
    .first_value_o  (first_value_o),
    .second_index_o (second_index_o),
    .second_value_o (second_value_o),
    .pair_valid_o   (pair_valid_o),
    .delta_samples_o(delta_samples_o),
    .delta_min_o    (delta_min_o),
    .delta_max_o    (delta_max_o)
  );

  `ASSERT_IMPLIES(a_delta_in_range, clk_i, rst_ni,
    out_valid_o && pair_valid_o,
    delta_min_o <= delta_samples_o && delta_samples_o <= delta_max_o,
    "valid delta outside running min/max")
  `ASSERT_IMPLIES(a_invalid_zero_delta, clk_i, rst_ni,
    out_valid_o && !pair_valid_o, delta_samples_o == '0,
    "invalid pair with nonzero delta")
  `ASSERT_IMPLIES(a_stall_cause, clk_i, rst_ni, !in_ready_o,
    s1_valid_q && s1_last_q && out_valid_o && !out_ready_i,
    "input stalled without a blocked result")
  `ASSERT_NEXT(a_result_follows_last, clk_i, rst_ni, s1_go && s1_last_q, out_valid_o,
    "last sample did not produce a result")

endmodule
